// File: rtl/core/gnt_pkg.sv
// shared constants, types, permutation rom and noise helpers for the turbulence block
package gnt_pkg;

	localparam int MAX_OCTAVES_DEF = 8;
	localparam int FRAC_BITS = 16;
	localparam int POS_W = 32;
	localparam int SCALE_W = 44;
	localparam int SCALE_FRAC = 12;
	localparam int WT_W = 36;
	localparam int GAIN_FRAC = 14;
	localparam int OCT_W = 4;
	localparam int LAC_W = 16;
	localparam int GAIN_W = 16;
	localparam int CFG_W = 16;
	localparam int CFG_IDX_W = 2;

	localparam int CRD_W = FRAC_BITS + 8;
	localparam int FR_W = FRAC_BITS + 1;
	localparam int GR_W = FRAC_BITS + 2;
	localparam int FD_W = FRAC_BITS + 2;
	localparam int LV_W = FRAC_BITS + 4;
	localparam int TERM_W = LV_W + WT_W + 1 - GAIN_FRAC;
	localparam int SUM_W = TERM_W + 5;
	localparam int CELL_LAT = 11;

	localparam logic [SCALE_W-1:0] SCALE_ONE = SCALE_W'(1) << SCALE_FRAC;
	localparam logic [WT_W-1:0] WT_ONE = WT_W'(1) << GAIN_FRAC;

	localparam logic [CFG_IDX_W-1:0] CFG_OCT_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LACUNARITY = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ABS_MODE = 2'd3;

	typedef struct packed {
		logic vld;
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [POS_W-1:0] pos_z;
		logic [SCALE_W-1:0] scale;
		logic [WT_W-1:0] weight;
		logic signed [SUM_W-1:0] sum;
	} oct_t;

	localparam logic [7:0] PERM [256] = '{
		8'd151, 8'd160, 8'd137, 8'd91, 8'd90, 8'd15,
		8'd131, 8'd13, 8'd201, 8'd95, 8'd96, 8'd53, 8'd194, 8'd233, 8'd7, 8'd225,
		8'd140, 8'd36, 8'd103, 8'd30, 8'd69, 8'd142, 8'd8, 8'd99, 8'd37, 8'd240,
		8'd21, 8'd10, 8'd23,
		8'd190, 8'd6, 8'd148, 8'd247, 8'd120, 8'd234, 8'd75, 8'd0, 8'd26, 8'd197,
		8'd62, 8'd94, 8'd252, 8'd219, 8'd203, 8'd117, 8'd35, 8'd11, 8'd32, 8'd57,
		8'd177, 8'd33,
		8'd88, 8'd237, 8'd149, 8'd56, 8'd87, 8'd174, 8'd20, 8'd125, 8'd136, 8'd171,
		8'd168, 8'd68, 8'd175, 8'd74, 8'd165, 8'd71, 8'd134, 8'd139, 8'd48, 8'd27,
		8'd166,
		8'd77, 8'd146, 8'd158, 8'd231, 8'd83, 8'd111, 8'd229, 8'd122, 8'd60, 8'd211,
		8'd133, 8'd230, 8'd220, 8'd105, 8'd92, 8'd41, 8'd55, 8'd46, 8'd245, 8'd40,
		8'd244,
		8'd102, 8'd143, 8'd54, 8'd65, 8'd25, 8'd63, 8'd161, 8'd1, 8'd216, 8'd80,
		8'd73, 8'd209, 8'd76, 8'd132, 8'd187, 8'd208, 8'd89, 8'd18, 8'd169, 8'd200,
		8'd196,
		8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86, 8'd164, 8'd100, 8'd109,
		8'd198, 8'd173, 8'd186, 8'd3, 8'd64, 8'd52, 8'd217, 8'd226, 8'd250, 8'd124,
		8'd123,
		8'd5, 8'd202, 8'd38, 8'd147, 8'd118, 8'd126, 8'd255, 8'd82, 8'd85, 8'd212,
		8'd207, 8'd206, 8'd59, 8'd227, 8'd47, 8'd16, 8'd58, 8'd17, 8'd182, 8'd189,
		8'd28, 8'd42,
		8'd223, 8'd183, 8'd170, 8'd213, 8'd119, 8'd248, 8'd152, 8'd2, 8'd44, 8'd154,
		8'd163, 8'd70, 8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43, 8'd172, 8'd9,
		8'd129, 8'd22, 8'd39, 8'd253, 8'd19, 8'd98, 8'd108, 8'd110, 8'd79, 8'd113,
		8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104, 8'd218, 8'd246, 8'd97,
		8'd228,
		8'd251, 8'd34, 8'd242, 8'd193, 8'd238, 8'd210, 8'd144, 8'd12, 8'd191, 8'd179,
		8'd162, 8'd241, 8'd81, 8'd51, 8'd145, 8'd235, 8'd249, 8'd14, 8'd239, 8'd107,
		8'd49, 8'd192, 8'd214, 8'd31, 8'd181, 8'd199, 8'd106, 8'd157, 8'd184, 8'd84,
		8'd204, 8'd176, 8'd115, 8'd121, 8'd50, 8'd45, 8'd127, 8'd4, 8'd150, 8'd254,
		8'd138, 8'd236, 8'd205, 8'd93, 8'd222, 8'd114, 8'd67, 8'd29, 8'd24, 8'd72,
		8'd243, 8'd141, 8'd128, 8'd195, 8'd78, 8'd66, 8'd215, 8'd61, 8'd156, 8'd180
	};

	function automatic logic [7:0] perm(input logic [7:0] idx);
		return PERM[idx];
	endfunction

	// gradient along one of the cube edge directions, picked by hash bits [3:0]
	function automatic logic signed [GR_W-1:0] grad(input logic [3:0] h,
			input logic signed [FR_W-1:0] x, input logic signed [FR_W-1:0] y,
			input logic signed [FR_W-1:0] z);
		logic signed [GR_W-1:0] u;
		logic signed [GR_W-1:0] v;
		u = (h < 4'd8) ? GR_W'(x) : GR_W'(y);
		if (h < 4'd4)
			v = GR_W'(y);
		else if (h == 4'd12 || h == 4'd14)
			v = GR_W'(x);
		else
			v = GR_W'(z);
		if (h[0])
			u = -u;
		if (h[1])
			v = -v;
		return u + v;
	endfunction

	function automatic logic signed [LV_W-1:0] lerp(input logic [FD_W-1:0] t,
			input logic signed [LV_W-1:0] a, input logic signed [LV_W-1:0] b);
		logic signed [LV_W:0] d;
		logic signed [LV_W+FD_W+1:0] p;
		d = (LV_W+1)'(b) - (LV_W+1)'(a);
		p = $signed({1'b0, t}) * d;
		return LV_W'(p >>> FRAC_BITS) + a;
	endfunction

endpackage

// File: rtl/core/gradient_noise_turbulence.sv
// top level: config registers, chain of octave cells, output register with skid stage
//
// Fractal gradient-noise evaluator. A point (pos_x, pos_y, pos_z, signed Q15.16)
// is taken on the input channel when in_valid is high and in_stall is low; one
// noise_sum beat (signed Q15.16, saturated) leaves on the output channel when
// out_valid is high and out_stall is low. Results come out in input order.
// The point walks through a chain of MAX_OCTAVES cells, one per octave, each a
// pipeline of 11 stages; the octave_count register masks the cells that add.
// One point is taken every cycle for as long as output flows. The output has a
// register plus one skid stage: when the receiver stalls, the next result that
// leaves the chain goes into the skid stage, then the chain holds and in_stall
// rises; it falls again in the cycle after the waiting result is taken.
// Configuration is written through cfg_we / cfg_index / cfg_data; the user must
// write only while no point is in flight, as the block does not enforce this.
// Writes land at the next clock edge. Reset clears the configuration to one
// octave, lacunarity 2.0, gain 0.5, signed summing, and empties the pipeline.
module gradient_noise_turbulence import gnt_pkg::*; #(
	parameter int MAX_OCTAVES = MAX_OCTAVES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [POS_W-1:0]     pos_x,
	input  logic signed [POS_W-1:0]     pos_y,
	input  logic signed [POS_W-1:0]     pos_z,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [31:0]          noise_sum,
	input  logic                        cfg_we,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_W-1:0]            cfg_data
);

	logic [OCT_W-1:0] octave_count_q;
	logic [LAC_W-1:0] lacunarity_q;
	logic [GAIN_W-1:0] octave_gain_q;
	logic abs_mode_q;

	oct_t chain [MAX_OCTAVES+1];
	oct_t last;
	logic adv;
	logic take;
	logic out_vld_q;
	logic skid_vld_q;
	logic signed [31:0] out_data_q;
	logic signed [31:0] skid_data_q;
	logic signed [31:0] sat;

	assign adv = !skid_vld_q;
	assign in_stall = skid_vld_q;
	assign out_valid = out_vld_q;
	assign noise_sum = out_data_q;
	assign take = out_vld_q && !out_stall;
	assign last = chain[MAX_OCTAVES];

	always_comb begin
		chain[0].vld = in_valid && adv;
		chain[0].pos_x = pos_x;
		chain[0].pos_y = pos_y;
		chain[0].pos_z = pos_z;
		chain[0].scale = SCALE_ONE;
		chain[0].weight = WT_ONE;
		chain[0].sum = '0;
		// clamp to the signed 32-bit range
		if (&last.sum[SUM_W-1:31] || ~|last.sum[SUM_W-1:31])
			sat = last.sum[31:0];
		else if (last.sum[SUM_W-1])
			sat = {1'b1, 31'd0};
		else
			sat = {1'b0, {31{1'b1}}};
	end

	for (genvar g = 0; g < MAX_OCTAVES; g++) begin : g_cell
		gnt_cell #(.OCT_IDX(g)) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.adv(adv),
			.octave_count(octave_count_q),
			.lacunarity(lacunarity_q),
			.octave_gain(octave_gain_q),
			.abs_mode(abs_mode_q),
			.oct_in(chain[g]),
			.oct_out(chain[g+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			octave_count_q <= OCT_W'(1);
			lacunarity_q <= LAC_W'(8192);
			octave_gain_q <= GAIN_W'(8192);
			abs_mode_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_OCT_COUNT: octave_count_q <= cfg_data[OCT_W-1:0];
				CFG_LACUNARITY: lacunarity_q <= cfg_data[LAC_W-1:0];
				CFG_GAIN: octave_gain_q <= cfg_data[GAIN_W-1:0];
				CFG_ABS_MODE: abs_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (adv && last.vld) begin
			if (!out_vld_q || take)
				out_vld_q <= 1'b1;
			else
				skid_vld_q <= 1'b1;
		end else if (take) begin
			out_vld_q <= skid_vld_q;
			skid_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last.vld) begin
			if (!out_vld_q || take)
				out_data_q <= sat;
			else
				skid_data_q <= sat;
		end else if (take && skid_vld_q) begin
			out_data_q <= skid_data_q;
		end
	end

`ifndef SYNTH
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid stage full while output register empty");

	a_stall_fills_skid: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && out_stall && adv && last.vld |=> skid_vld_q)
		else $error("result arriving under stall not kept in skid stage");

	a_skid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q && out_stall |=> skid_vld_q && $stable(skid_data_q))
		else $error("skid beat lost while receiver stalls");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q && !out_stall |=> out_vld_q && !skid_vld_q)
		else $error("skid beat not moved to output after take");
`endif

endmodule

// File: rtl/core/gnt_fade.sv
// three-stage quintic fade curve 6t^5 - 15t^4 + 10t^3 in fixed point
module gnt_fade import gnt_pkg::*; (
	input  logic                 clk,
	input  logic                 adv,
	input  logic [FRAC_BITS-1:0] t,
	output logic [FD_W-1:0]      fade
);

	localparam int IN_W = FRAC_BITS + 5;
	localparam logic signed [IN_W-1:0] K15 = IN_W'(15) <<< FRAC_BITS;
	localparam logic signed [IN_W-1:0] K10 = IN_W'(10) <<< FRAC_BITS;

	logic [FRAC_BITS+2:0] t6;
	logic signed [IN_W-1:0] d;
	logic signed [2*FRAC_BITS+IN_W:0] pin;
	logic [2*FRAC_BITS-1:0] sq;
	logic [2*FRAC_BITS-1:0] cube;
	logic signed [FRAC_BITS+IN_W:0] pfd;

	logic [FRAC_BITS-1:0] t_s1;
	logic [FRAC_BITS-1:0] t2_s1;
	logic signed [IN_W-1:0] inner_s1;
	logic [FRAC_BITS-1:0] t3_s2;
	logic signed [IN_W-1:0] inner_s2;
	logic [FD_W-1:0] fade_s3;

	always_comb begin
		t6 = (FRAC_BITS+3)'({t, 2'b0}) + (FRAC_BITS+3)'({t, 1'b0});
		d = $signed(IN_W'(t6)) - K15;
		pin = $signed({1'b0, t}) * d;
		sq = t * t;
		cube = t2_s1 * t_s1;
		pfd = $signed({1'b0, t3_s2}) * inner_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s1 <= t;
			t2_s1 <= sq[2*FRAC_BITS-1:FRAC_BITS];
			inner_s1 <= IN_W'(pin >>> FRAC_BITS) + K10;
			t3_s2 <= cube[2*FRAC_BITS-1:FRAC_BITS];
			inner_s2 <= inner_s1;
			fade_s3 <= FD_W'(pfd >>> FRAC_BITS);
		end
	end

	assign fade = fade_s3;

endmodule

// File: rtl/core/gnt_cell.sv
// one octave cell: scales the point, evaluates gradient noise and adds the weighted term
module gnt_cell import gnt_pkg::*; #(
	parameter int OCT_IDX = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic [OCT_W-1:0]  octave_count,
	input  logic [LAC_W-1:0]  lacunarity,
	input  logic [GAIN_W-1:0] octave_gain,
	input  logic              abs_mode,
	input  oct_t              oct_in,
	output oct_t              oct_out
);

	localparam int SPLIT = SCALE_W / 2;
	localparam int HI_W = SCALE_W - SPLIT;
	localparam logic [OCT_W:0] IDX = (OCT_W+1)'(OCT_IDX);
	localparam logic signed [FR_W-1:0] ONE_Q = FR_W'(1) <<< FRAC_BITS;

	typedef struct packed {
		logic vld;
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [POS_W-1:0] pos_z;
		logic [SCALE_W-1:0] scale_nxt;
		logic [WT_W-1:0] weight;
		logic [WT_W-1:0] weight_nxt;
		logic signed [SUM_W-1:0] sum;
	} side_t;

	side_t side_s [1:CELL_LAT-1];

	logic signed [POS_W-1:0] pos [3];
	logic [SCALE_W+LAC_W-1:0] sprod;
	logic [WT_W+GAIN_W-1:0] wprod;
	logic [WT_W+GAIN_W-GAIN_FRAC-1:0] wsh;
	logic [WT_W-1:0] weight_nxt;
	logic [SCALE_W-1:0] p44 [3];
	logic [SCALE_W+SPLIT-1:0] plo [3];
	logic [SPLIT+HI_W-1:0] phi [3];
	logic [SCALE_W-1:0] full [3];

	logic [SCALE_W-1:0] m0_s1 [3];
	logic [HI_W-1:0] m1_s1 [3];
	logic [CRD_W-1:0] crd_s2 [3];

	logic [7:0] px_s3, px1_s3, ly_s3, lz_s3, lz_s4;
	logic [7:0] pa_s4, pa1_s4, pb_s4, pb1_s4;
	logic [7:0] hash_s5 [8];
	logic [FRAC_BITS-1:0] fx_s3, fy_s3, fz_s3, fx_s4, fy_s4, fz_s4, fx_s5, fy_s5, fz_s5;
	logic [FD_W-1:0] fu, fv, fw;
	logic [FD_W-1:0] u_s6, v_s6, w_s6, v_s7, w_s7, w_s8;
	logic signed [FR_W-1:0] x0, y0, z0, x1, y1, z1;
	logic signed [GR_W-1:0] grad_s6 [8];
	logic signed [LV_W-1:0] lx_s7 [4];
	logic signed [LV_W-1:0] nx_s8 [2];
	logic signed [LV_W-1:0] nz_s9;
	logic signed [LV_W-1:0] mag;
	logic signed [LV_W+WT_W:0] tprod;
	logic signed [TERM_W-1:0] term_s10;
	logic active;

	always_comb begin
		pos[0] = oct_in.pos_x;
		pos[1] = oct_in.pos_y;
		pos[2] = oct_in.pos_z;
		sprod = oct_in.scale * lacunarity;
		wprod = oct_in.weight * octave_gain;
		wsh = wprod[WT_W+GAIN_W-1:GAIN_FRAC];
		// weight saturates at the top of its range
		weight_nxt = (|wsh[WT_W+GAIN_W-GAIN_FRAC-1:WT_W]) ? '1 : wsh[WT_W-1:0];
		for (int k = 0; k < 3; k++) begin
			p44[k] = {{(SCALE_W-POS_W){pos[k][POS_W-1]}}, pos[k]};
			plo[k] = p44[k] * oct_in.scale[SPLIT-1:0];
			phi[k] = p44[k][SPLIT-1:0] * oct_in.scale[SCALE_W-1:SPLIT];
			full[k] = m0_s1[k] + {m1_s1[k], SPLIT'(0)};
		end
	end

	always_comb begin
		x0 = $signed({1'b0, fx_s5});
		y0 = $signed({1'b0, fy_s5});
		z0 = $signed({1'b0, fz_s5});
		x1 = x0 - ONE_Q;
		y1 = y0 - ONE_Q;
		z1 = z0 - ONE_Q;
		mag = (abs_mode && nz_s9 < 0) ? -nz_s9 : nz_s9;
		tprod = mag * $signed({1'b0, side_s[CELL_LAT-2].weight});
		active = {1'b0, octave_count} > IDX;
	end

	gnt_fade u_fade_x (.clk(clk), .adv(adv), .t(crd_s2[0][FRAC_BITS-1:0]), .fade(fu));
	gnt_fade u_fade_y (.clk(clk), .adv(adv), .t(crd_s2[1][FRAC_BITS-1:0]), .fade(fv));
	gnt_fade u_fade_z (.clk(clk), .adv(adv), .t(crd_s2[2][FRAC_BITS-1:0]), .fade(fw));

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				m0_s1[k] <= plo[k][SCALE_W-1:0];
				m1_s1[k] <= phi[k][HI_W-1:0];
				crd_s2[k] <= full[k][SCALE_FRAC+CRD_W-1:SCALE_FRAC];
			end
			// hash, three rom levels
			px_s3 <= perm(crd_s2[0][CRD_W-1:FRAC_BITS]);
			px1_s3 <= perm(crd_s2[0][CRD_W-1:FRAC_BITS] + 8'd1);
			ly_s3 <= crd_s2[1][CRD_W-1:FRAC_BITS];
			lz_s3 <= crd_s2[2][CRD_W-1:FRAC_BITS];
			pa_s4 <= perm(px_s3 + ly_s3);
			pa1_s4 <= perm(px_s3 + ly_s3 + 8'd1);
			pb_s4 <= perm(px1_s3 + ly_s3);
			pb1_s4 <= perm(px1_s3 + ly_s3 + 8'd1);
			lz_s4 <= lz_s3;
			hash_s5[0] <= perm(pa_s4 + lz_s4);
			hash_s5[1] <= perm(pb_s4 + lz_s4);
			hash_s5[2] <= perm(pa1_s4 + lz_s4);
			hash_s5[3] <= perm(pb1_s4 + lz_s4);
			hash_s5[4] <= perm(pa_s4 + lz_s4 + 8'd1);
			hash_s5[5] <= perm(pb_s4 + lz_s4 + 8'd1);
			hash_s5[6] <= perm(pa1_s4 + lz_s4 + 8'd1);
			hash_s5[7] <= perm(pb1_s4 + lz_s4 + 8'd1);
			fx_s3 <= crd_s2[0][FRAC_BITS-1:0];
			fy_s3 <= crd_s2[1][FRAC_BITS-1:0];
			fz_s3 <= crd_s2[2][FRAC_BITS-1:0];
			fx_s4 <= fx_s3;
			fy_s4 <= fy_s3;
			fz_s4 <= fz_s3;
			fx_s5 <= fx_s4;
			fy_s5 <= fy_s4;
			fz_s5 <= fz_s4;
			grad_s6[0] <= grad(hash_s5[0][3:0], x0, y0, z0);
			grad_s6[1] <= grad(hash_s5[1][3:0], x1, y0, z0);
			grad_s6[2] <= grad(hash_s5[2][3:0], x0, y1, z0);
			grad_s6[3] <= grad(hash_s5[3][3:0], x1, y1, z0);
			grad_s6[4] <= grad(hash_s5[4][3:0], x0, y0, z1);
			grad_s6[5] <= grad(hash_s5[5][3:0], x1, y0, z1);
			grad_s6[6] <= grad(hash_s5[6][3:0], x0, y1, z1);
			grad_s6[7] <= grad(hash_s5[7][3:0], x1, y1, z1);
			u_s6 <= fu;
			v_s6 <= fv;
			w_s6 <= fw;
			for (int j = 0; j < 4; j++)
				lx_s7[j] <= lerp(u_s6, LV_W'(grad_s6[2*j]), LV_W'(grad_s6[2*j+1]));
			v_s7 <= v_s6;
			w_s7 <= w_s6;
			nx_s8[0] <= lerp(v_s7, lx_s7[0], lx_s7[1]);
			nx_s8[1] <= lerp(v_s7, lx_s7[2], lx_s7[3]);
			w_s8 <= w_s7;
			nz_s9 <= lerp(w_s8, nx_s8[0], nx_s8[1]);
			term_s10 <= TERM_W'(tprod >>> GAIN_FRAC);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 1; j < CELL_LAT; j++)
				side_s[j] <= '0;
			oct_out <= '0;
		end else if (adv) begin
			side_s[1].vld <= oct_in.vld;
			side_s[1].pos_x <= oct_in.pos_x;
			side_s[1].pos_y <= oct_in.pos_y;
			side_s[1].pos_z <= oct_in.pos_z;
			side_s[1].scale_nxt <= sprod[SCALE_FRAC+SCALE_W-1:SCALE_FRAC];
			side_s[1].weight <= oct_in.weight;
			side_s[1].weight_nxt <= weight_nxt;
			side_s[1].sum <= oct_in.sum;
			for (int j = 2; j < CELL_LAT; j++)
				side_s[j] <= side_s[j-1];
			oct_out.vld <= side_s[CELL_LAT-1].vld;
			oct_out.pos_x <= side_s[CELL_LAT-1].pos_x;
			oct_out.pos_y <= side_s[CELL_LAT-1].pos_y;
			oct_out.pos_z <= side_s[CELL_LAT-1].pos_z;
			oct_out.scale <= side_s[CELL_LAT-1].scale_nxt;
			oct_out.weight <= side_s[CELL_LAT-1].weight_nxt;
			oct_out.sum <= active ? side_s[CELL_LAT-1].sum + SUM_W'(term_s10)
				: side_s[CELL_LAT-1].sum;
		end
	end

endmodule

// File: test/gnt_checker.sv
// checker for the turbulence block: predicts each noise sum and compares output beats
module gnt_checker import gnt_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic                    in_stall,
	input  logic signed [POS_W-1:0] pos_x,
	input  logic signed [POS_W-1:0] pos_y,
	input  logic signed [POS_W-1:0] pos_z,
	input  logic                    out_valid,
	input  logic                    out_stall,
	input  logic signed [31:0]      noise_sum,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]        cfg_data,
	output int                      mismatches,
	output int                      pending
);

	localparam longint UNIT = longint'(1) << FRAC_BITS;

	logic [OCT_W-1:0]  m_octaves;
	logic [LAC_W-1:0]  m_lacunarity;
	logic [GAIN_W-1:0] m_gain;
	logic              m_abs;
	logic signed [31:0] sum_queue[$];

	function automatic longint fmul(longint a, longint b);
		return (a * b) >>> FRAC_BITS;
	endfunction

	function automatic longint fade_curve(longint t);
		longint inner;
		inner = fmul(t, 6 * t - 15 * UNIT) + 10 * UNIT;
		return fmul(fmul(fmul(t, t), t), inner);
	endfunction

	function automatic longint blend(longint t, longint a, longint b);
		return a + fmul(t, b - a);
	endfunction

	function automatic longint corner_grad(int hash, longint x, longint y, longint z);
		int h;
		longint u;
		longint v;
		h = hash & 15;
		u = (h < 8) ? x : y;
		v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
		return ((h & 1) ? -u : u) + ((h & 2) ? -v : v);
	endfunction

	function automatic int rom(int i);
		return int'(PERM[i & 255]);
	endfunction

	function automatic longint lattice_noise(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz);
		int gx, gy, gz, a, aa, ab, b, ba, bb;
		longint x, y, z, x1, y1, z1, u, v, w, n0, n1;
		gx = int'(cx[23:16]);
		gy = int'(cy[23:16]);
		gz = int'(cz[23:16]);
		x = longint'(cx[15:0]);
		y = longint'(cy[15:0]);
		z = longint'(cz[15:0]);
		u = fade_curve(x);
		v = fade_curve(y);
		w = fade_curve(z);
		a = rom(gx) + gy;
		aa = rom(a) + gz;
		ab = rom(a + 1) + gz;
		b = rom(gx + 1) + gy;
		ba = rom(b) + gz;
		bb = rom(b + 1) + gz;
		x1 = x - UNIT;
		y1 = y - UNIT;
		z1 = z - UNIT;
		n0 = blend(v, blend(u, corner_grad(rom(aa), x, y, z), corner_grad(rom(ba), x1, y, z)),
			blend(u, corner_grad(rom(ab), x, y1, z), corner_grad(rom(bb), x1, y1, z)));
		n1 = blend(v,
			blend(u, corner_grad(rom(aa + 1), x, y, z1), corner_grad(rom(ba + 1), x1, y, z1)),
			blend(u, corner_grad(rom(ab + 1), x, y1, z1), corner_grad(rom(bb + 1), x1, y1, z1)));
		return blend(w, n0, n1);
	endfunction

	function automatic logic signed [31:0] turbulence(logic signed [31:0] px,
			logic signed [31:0] py, logic signed [31:0] pz);
		logic [63:0] scale, weight, ex, ey, ez, prx, pry, prz;
		longint total, nz;
		int count;
		scale = 64'd1 << SCALE_FRAC;
		weight = 64'd1 << GAIN_FRAC;
		total = 0;
		count = (m_octaves > MAX_OCTAVES_DEF) ? MAX_OCTAVES_DEF : int'(m_octaves);
		ex = 64'(px);
		ey = 64'(py);
		ez = 64'(pz);
		for (int i = 0; i < count; i++) begin
			prx = ex * scale;
			pry = ey * scale;
			prz = ez * scale;
			nz = lattice_noise(prx[43:12], pry[43:12], prz[43:12]);
			if (m_abs && nz < 0)
				nz = -nz;
			total += (nz * longint'(weight)) >>> GAIN_FRAC;
			scale = ((scale * m_lacunarity) >> SCALE_FRAC) & ((64'd1 << 44) - 1);
			weight = (weight * m_gain) >> GAIN_FRAC;
			if (weight > (64'd1 << 36) - 1)
				weight = (64'd1 << 36) - 1;
		end
		if (total > 64'sd2147483647)
			total = 64'sd2147483647;
		if (total < -64'sd2147483648)
			total = -64'sd2147483648;
		return total[31:0];
	endfunction

	assign pending = sum_queue.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_octaves <= 4'd1;
			m_lacunarity <= 16'd8192;
			m_gain <= 16'd8192;
			m_abs <= 1'b0;
			sum_queue.delete();
			mismatches <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_OCT_COUNT: m_octaves <= cfg_data[OCT_W-1:0];
					CFG_LACUNARITY: m_lacunarity <= cfg_data;
					CFG_GAIN: m_gain <= cfg_data;
					CFG_ABS_MODE: m_abs <= cfg_data[0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (sum_queue.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected beat: noise_sum %0d", noise_sum);
					mismatches <= mismatches + 1;
				end else begin
					if (sum_queue[0] !== noise_sum) begin
						if (mismatches < 10)
							$display("noise_sum: expected %0d, got %0d", sum_queue[0], noise_sum);
						mismatches <= mismatches + 1;
					end
					void'(sum_queue.pop_front());
				end
			end
			if (in_valid && !in_stall)
				sum_queue.push_back(turbulence(pos_x, pos_y, pos_z));
		end
	end

endmodule

// File: test/gradient_noise_turbulence_tb.sv
// testbench top: drives points and register writes into the turbulence block
module gradient_noise_turbulence_tb;
	import gnt_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [POS_W-1:0] pos_x = '0;
	logic signed [POS_W-1:0] pos_y = '0;
	logic signed [POS_W-1:0] pos_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] noise_sum;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic steady = 1'b0;
	int mismatches;
	int pending;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	gradient_noise_turbulence DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.out_valid(out_valid), .out_stall(out_stall), .noise_sum(noise_sum),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	gnt_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.out_valid(out_valid), .out_stall(out_stall), .noise_sum(noise_sum),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.mismatches(mismatches), .pending(pending)
	);

	always @(posedge clk)
		out_stall <= !steady && ($urandom_range(99) < 15);

	task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		while (!steady && $urandom_range(99) < 15) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		pos_x <= x;
		pos_y <= y;
		pos_z <= z;
		do @(posedge clk); while (in_stall);
	endtask

	// drain the pipeline, then write one register
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		in_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_all(logic [3:0] oct, logic [15:0] lac, logic [15:0] gn, logic ab);
		write_reg(CFG_OCT_COUNT, 16'(oct));
		write_reg(CFG_LACUNARITY, lac);
		write_reg(CFG_GAIN, gn);
		write_reg(CFG_ABS_MODE, 16'(ab));
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(3))
			0: return $urandom();
			1: return 32'($signed($urandom_range(2097151)) - 1048576);
			2: return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom())};
			default: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
		endcase
	endfunction

	initial begin
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		logic [3:0] oct;
		logic [15:0] lac, gn;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// reset settings: one octave
		send_point(32'h0, 32'h0, 32'h0);
		send_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
		send_point(32'h80000000, 32'h80000000, 32'h80000000);
		send_point(32'h00008000, 32'h0001ffff, 32'hffff0001);
		send_point(32'h00ff0000, 32'h01000000, 32'hff7fffff);
		// no octaves at all
		set_all(4'd0, 16'd8192, 16'd8192, 1'b0);
		send_point(32'h12345678, 32'h9abcdef0, 32'h0f0f0f0f);
		send_point(32'h7fffffff, 32'h80000000, 32'h0);
		// more octaves than the chain holds, extreme multipliers
		set_all(4'd15, 16'hffff, 16'hffff, 1'b1);
		send_point(32'h7fffffff, 32'h80000000, 32'h00018000);
		send_point(32'h80000000, 32'h7fffffff, 32'hfffe8000);
		send_point(32'h0000ffff, 32'hffff0000, 32'h55555555);
		send_point(32'haaaaaaaa, 32'h55555555, 32'hffffffff);
		set_all(4'd8, 16'd0, 16'd0, 1'b0);
		send_point(32'h00030000, 32'h00051234, 32'hfff0abcd);
		send_point(32'h7fffffff, 32'h7fffffff, 32'h80000000);
		set_all(4'd8, 16'd8192, 16'hffff, 1'b1);
		send_point(32'h00048000, 32'hfffb8000, 32'h00000001);
		send_point(32'hdeadbeef, 32'hcafef00d, 32'h01234567);
		set_all(4'd9, 16'd4096, 16'd16384, 1'b0);
		send_point(32'h00010000, 32'h00020000, 32'h00030000);
		send_point(32'hfffeffff, 32'h7ffeffff, 32'h80010000);

		for (int phase = 0; phase < 10; phase++) begin
			oct = (phase < 2) ? 4'(phase * 8) : 4'($urandom_range(15));
			lac = (phase == 3) ? 16'hffff : ((phase == 4) ? 16'd0 : 16'($urandom()));
			gn = (phase == 5) ? 16'hffff : ((phase == 6) ? 16'd0 : 16'($urandom()));
			if ($urandom_range(1))
				lac = 16'($urandom_range(16383));
			set_all(oct, lac, gn, phase[0]);
			for (int n = 0; n < 83; n++) begin
				steady <= (phase == 2);
				send_point(rand_coord(), rand_coord(), rand_coord());
			end
			steady <= 1'b0;
		end

		in_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (120) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
